// ===== hdl/eqr_pkg.sv =====
// ----------------------------------------------------------------------------
// eqr_pkg
// Shared constants and helper functions for the Euler-angle quaternion
// vector rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eqr_pkg;

    localparam int VEC_WIDTH_DEF  = 32;
    localparam int QUAT_FRAC_DEF  = 16;

    // angle registers, 1/128 degree
    localparam int ANG_W          = 17;
    localparam int HALF_TURN      = 23040;
    localparam int FULL_TURN      = 46080;
    localparam int QUARTER_TURN   = 11520;

    // CORDIC: Q4.30 datapath, angle in degrees * 2^24
    localparam int CORDIC_ITERS   = 30;
    localparam int CORDIC_FRAC    = 30;
    localparam int CORDIC_W       = 34;
    localparam int ITER_W         = 5;
    localparam int TRIG_W         = 32;
    localparam longint DEG_PER_RAD_Q24 = 961263669;
    localparam longint CORDIC_X0       = 652032874;

    // APB register map
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 4;
    localparam logic [1:0] REG_ROLL  = 2'd0;
    localparam logic [1:0] REG_PITCH = 2'd1;
    localparam logic [1:0] REG_YAW   = 2'd2;

    // rotation angle step for CORDIC iteration i
    function automatic logic signed [CORDIC_W-1:0] cordic_step(input logic [ITER_W-1:0] i);
        logic [CORDIC_W-1:0] t;
        logic signed [CORDIC_W-1:0] res;
        t = CORDIC_W'(DEG_PER_RAD_Q24) + (CORDIC_W'(1) << (i - ITER_W'(1)));
        case (i)
            5'd0:    res = 34'sd754974720;
            5'd1:    res = 34'sd445687602;
            5'd2:    res = 34'sd235489088;
            5'd3:    res = 34'sd119537938;
            5'd4:    res = 34'sd60000934;
            5'd5:    res = 34'sd30029717;
            5'd6:    res = 34'sd15018523;
            5'd7:    res = 34'sd7509720;
            5'd8:    res = 34'sd3754917;
            5'd9:    res = 34'sd1877466;
            5'd10:   res = 34'sd938734;
            default: res = $signed(t >> i);
        endcase
        return res;
    endfunction

    // Operand choice for the eight triple products of the quaternion:
    // bit 2 roll, bit 1 pitch, bit 0 yaw; 1 selects sine, 0 cosine.
    function automatic logic [2:0] tri_sel(input logic [2:0] k);
        logic [2:0] res;
        case (k)
            3'd0:    res = 3'b000;
            3'd1:    res = 3'b111;
            3'd2:    res = 3'b100;
            3'd3:    res = 3'b011;
            3'd4:    res = 3'b010;
            3'd5:    res = 3'b101;
            3'd6:    res = 3'b001;
            default: res = 3'b110;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/eqr_if.sv =====
// ----------------------------------------------------------------------------
// eqr_in_if / eqr_out_if
// Valid/ready channels carrying input vectors and rotated results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eqr_in_if import eqr_pkg::*; #(
    parameter int VW = VEC_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic signed [VW-1:0] in_x;
    logic signed [VW-1:0] in_y;
    logic signed [VW-1:0] in_z;

    modport source (output valid, action, in_x, in_y, in_z, input ready);
    modport sink   (input valid, action, in_x, in_y, in_z, output ready);
endinterface

interface eqr_out_if import eqr_pkg::*; #(
    parameter int VW = VEC_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/eqr_quat_gen.sv =====
// ----------------------------------------------------------------------------
// eqr_quat_gen
// Wraps the angles, runs three CORDIC lanes on the half angles, forms the
// quaternion with a shared multiplier and expands it to a rotation matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eqr_quat_gen import eqr_pkg::*; #(
    parameter int QF = QUAT_FRAC_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ANG_W-1:0] i_roll,
    input  logic signed [ANG_W-1:0] i_pitch,
    input  logic signed [ANG_W-1:0] i_yaw,
    output logic                    o_busy,
    output logic signed [2*QF+3:0]  o_mat [9]
);

    localparam int QW = QF + 2;
    localparam int MW = 2 * QF + 4;
    localparam int EW = MW + 2;
    localparam int SH = CORDIC_FRAC - QF;
    localparam logic signed [CORDIC_W-1:0] Q_RND = CORDIC_W'((CORDIC_W'(1) << SH) >> 1);
    localparam logic signed [QW-1:0] Q_ONE = QW'(1) << QF;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WRAP   = 4'd1;
    localparam logic [3:0] ST_ROT    = 4'd2;
    localparam logic [3:0] ST_MUL_AB = 4'd3;
    localparam logic [3:0] ST_MUL_C  = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_QUAT   = 4'd6;
    localparam logic [3:0] ST_PROD   = 4'd7;
    localparam logic [3:0] ST_MAT    = 4'd8;

    logic [3:0]                 r_state;
    logic [ITER_W-1:0]          r_iter;
    logic [2:0]                 r_k;
    logic signed [CORDIC_W-1:0] r_x [3];
    logic signed [CORDIC_W-1:0] r_y [3];
    logic signed [CORDIC_W-1:0] r_z [3];
    logic signed [63:0]         r_prod;
    logic signed [CORDIC_W-1:0] r_acc [4];
    logic signed [QW-1:0]       r_q [4];   // s, ux, uy, uz
    logic signed [MW-1:0]       r_pp [10];
    logic signed [MW-1:0]       r_mat [9];

    logic signed [ANG_W-1:0]    n_ang [3];
    logic signed [CORDIC_W-1:0] n_step;
    logic signed [TRIG_W-1:0]   n_opa, n_opb, n_opc;
    logic signed [CORDIC_W-1:0] n_tri;
    logic [2:0]                 n_sel;

    function automatic logic signed [ANG_W-1:0] wrap180(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W+1:0] t;
        t = (ANG_W+2)'(a) + (ANG_W+2)'(HALF_TURN);
        if (t < 0) begin
            t = t + (ANG_W+2)'(FULL_TURN);
        end else if (t >= (ANG_W+2)'(FULL_TURN)) begin
            t = t - (ANG_W+2)'(FULL_TURN);
        end
        t = t - (ANG_W+2)'(HALF_TURN);
        return t[ANG_W-1:0];
    endfunction

    // round half up, drop CORDIC_FRAC bits
    function automatic logic signed [CORDIC_W-1:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (CORDIC_FRAC - 1))) >>> CORDIC_FRAC;
        return t[CORDIC_W-1:0];
    endfunction

    function automatic logic signed [QW-1:0] to_quat(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] t;
        logic signed [QW-1:0] res;
        t = (v + Q_RND) >>> SH;
        if (t > CORDIC_W'(Q_ONE)) begin
            res = Q_ONE;
        end else if (t < -CORDIC_W'(Q_ONE)) begin
            res = -Q_ONE;
        end else begin
            res = t[QW-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_ang[0] = wrap180(i_roll);
        n_ang[1] = wrap180(i_pitch);
        n_ang[2] = wrap180(i_yaw);
        // fold pitch into [-90, 90]
        if (n_ang[1] < -ANG_W'(QUARTER_TURN)) begin
            n_ang[1] = -ANG_W'(HALF_TURN) - n_ang[1];
        end else if (n_ang[1] > ANG_W'(QUARTER_TURN)) begin
            n_ang[1] = ANG_W'(HALF_TURN) - n_ang[1];
        end
        n_step = cordic_step(r_iter);
        n_sel  = tri_sel(r_k);
        n_opa  = n_sel[2] ? r_y[0][TRIG_W-1:0] : r_x[0][TRIG_W-1:0];
        n_opb  = n_sel[1] ? r_y[1][TRIG_W-1:0] : r_x[1][TRIG_W-1:0];
        n_opc  = n_sel[0] ? r_y[2][TRIG_W-1:0] : r_x[2][TRIG_W-1:0];
        n_tri  = rnd30(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
            r_k     <= '0;
            r_q[0]  <= Q_ONE;
            r_q[1]  <= '0;
            r_q[2]  <= '0;
            r_q[3]  <= '0;
            for (int e = 0; e < 9; e++) begin
                r_mat[e] <= (e % 4 == 0) ? (MW'(1) <<< (2 * QF)) : '0;
            end
        end else if (i_start) begin
            r_state <= ST_WRAP;
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_WRAP: begin
                    for (int l = 0; l < 3; l++) begin
                        r_x[l] <= CORDIC_W'(CORDIC_X0);
                        r_y[l] <= '0;
                        r_z[l] <= CORDIC_W'(n_ang[l]) <<< 16;
                    end
                    r_iter  <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    for (int l = 0; l < 3; l++) begin
                        if (r_z[l] >= 0) begin
                            r_x[l] <= r_x[l] - (r_y[l] >>> r_iter);
                            r_y[l] <= r_y[l] + (r_x[l] >>> r_iter);
                            r_z[l] <= r_z[l] - n_step;
                        end else begin
                            r_x[l] <= r_x[l] + (r_y[l] >>> r_iter);
                            r_y[l] <= r_y[l] - (r_x[l] >>> r_iter);
                            r_z[l] <= r_z[l] + n_step;
                        end
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(CORDIC_ITERS - 1)) begin
                        r_k     <= '0;
                        r_state <= ST_MUL_AB;
                    end
                end
                ST_MUL_AB: begin
                    r_prod  <= n_opa * n_opb;
                    r_state <= ST_MUL_C;
                end
                ST_MUL_C: begin
                    r_prod  <= $signed(n_tri[TRIG_W-1:0]) * n_opc;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    // odd terms of x and z subtract
                    if (!r_k[0]) begin
                        r_acc[r_k[2:1]] <= n_tri;
                    end else if (r_k == 3'd3 || r_k == 3'd7) begin
                        r_acc[r_k[2:1]] <= r_acc[r_k[2:1]] - n_tri;
                    end else begin
                        r_acc[r_k[2:1]] <= r_acc[r_k[2:1]] + n_tri;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 3'd7) ? ST_QUAT : ST_MUL_AB;
                end
                ST_QUAT: begin
                    for (int j = 0; j < 4; j++) begin
                        r_q[j] <= to_quat(r_acc[j]);
                    end
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_pp[0] <= r_q[0] * r_q[0];
                    r_pp[1] <= r_q[1] * r_q[1];
                    r_pp[2] <= r_q[2] * r_q[2];
                    r_pp[3] <= r_q[3] * r_q[3];
                    r_pp[4] <= r_q[1] * r_q[2];
                    r_pp[5] <= r_q[1] * r_q[3];
                    r_pp[6] <= r_q[2] * r_q[3];
                    r_pp[7] <= r_q[0] * r_q[1];
                    r_pp[8] <= r_q[0] * r_q[2];
                    r_pp[9] <= r_q[0] * r_q[3];
                    r_state <= ST_MAT;
                end
                ST_MAT: begin
                    r_mat[0] <= MW'(EW'(r_pp[0]) + EW'(r_pp[1]) - EW'(r_pp[2]) - EW'(r_pp[3]));
                    r_mat[4] <= MW'(EW'(r_pp[0]) - EW'(r_pp[1]) + EW'(r_pp[2]) - EW'(r_pp[3]));
                    r_mat[8] <= MW'(EW'(r_pp[0]) - EW'(r_pp[1]) - EW'(r_pp[2]) + EW'(r_pp[3]));
                    r_mat[1] <= MW'((EW'(r_pp[4]) - EW'(r_pp[9])) <<< 1);
                    r_mat[2] <= MW'((EW'(r_pp[5]) + EW'(r_pp[8])) <<< 1);
                    r_mat[3] <= MW'((EW'(r_pp[4]) + EW'(r_pp[9])) <<< 1);
                    r_mat[5] <= MW'((EW'(r_pp[6]) - EW'(r_pp[7])) <<< 1);
                    r_mat[6] <= MW'((EW'(r_pp[5]) - EW'(r_pp[8])) <<< 1);
                    r_mat[7] <= MW'((EW'(r_pp[6]) + EW'(r_pp[7])) <<< 1);
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_mat  = r_mat;

endmodule

`default_nettype wire

// ===== hdl/eqr_rot_pipe.sv =====
// ----------------------------------------------------------------------------
// eqr_rot_pipe
// Five-stage matrix-vector pipeline: operand select, partial products,
// product assembly, row sum with rounding, saturation into the output
// register. Each stage refills as soon as the next one has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eqr_rot_pipe import eqr_pkg::*; #(
    parameter int VW = VEC_WIDTH_DEF,
    parameter int QF = QUAT_FRAC_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_hold,
    input  logic signed [2*QF+3:0] i_mat [9],
    eqr_in_if.sink                 i_vec,
    eqr_out_if.source              o_res
);

    localparam int MW = 2 * QF + 4;
    localparam int ML = MW / 2;
    localparam int MH = MW - ML;
    localparam int VL = VW / 2;
    localparam int VH = VW - VL;
    localparam int PW = MW + VW;
    localparam int RW = PW + 2;
    localparam int OW = RW - 2 * QF;
    localparam logic signed [RW-1:0] HALF = RW'(1) <<< (2 * QF - 1);
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    logic [4:0] r_vld;
    logic [4:0] n_rdy;

    logic signed [MW-1:0]    r0_m [9];
    logic signed [VW-1:0]    r0_v [3];
    logic [ML+VL-1:0]        r1_ll [9];
    logic signed [ML+VH:0]   r1_lh [9];
    logic signed [MH+VL:0]   r1_hl [9];
    logic signed [MH+VH-1:0] r1_hh [9];
    logic signed [PW-1:0]    r2_p [9];
    logic signed [OW-1:0]    r3_row [3];
    logic signed [VW-1:0]    r_out [3];
    logic                    r_sat;

    logic signed [MW-1:0]    n0_m [9];
    logic [ML+VL-1:0]        n1_ll [9];
    logic signed [ML+VH:0]   n1_lh [9];
    logic signed [MH+VL:0]   n1_hl [9];
    logic signed [MH+VH-1:0] n1_hh [9];
    logic signed [PW-1:0]    n2_p [9];
    logic signed [RW-1:0]    n3_sum [3];
    logic signed [VW-1:0]    n4_out [3];
    logic [2:0]              n4_clip;

    always_comb begin
        n_rdy[4] = !r_vld[4] || o_res.ready;
        for (int k = 3; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    assign i_vec.ready = n_rdy[0] && !i_hold;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // the conjugate rotation is the transposed matrix
                n0_m[r*3+c]  = i_vec.action ? i_mat[c*3+r] : i_mat[r*3+c];
                n1_ll[r*3+c] = r0_m[r*3+c][ML-1:0] * r0_v[c][VL-1:0];
                n1_lh[r*3+c] = $signed({1'b0, r0_m[r*3+c][ML-1:0]})
                             * $signed(r0_v[c][VW-1:VL]);
                n1_hl[r*3+c] = $signed(r0_m[r*3+c][MW-1:ML])
                             * $signed({1'b0, r0_v[c][VL-1:0]});
                n1_hh[r*3+c] = $signed(r0_m[r*3+c][MW-1:ML])
                             * $signed(r0_v[c][VW-1:VL]);
                n2_p[r*3+c]  = (PW'(r1_hh[r*3+c]) <<< (ML + VL))
                             + (PW'(r1_hl[r*3+c]) <<< ML)
                             + (PW'(r1_lh[r*3+c]) <<< VL)
                             + $signed(PW'(r1_ll[r*3+c]));
            end
            n3_sum[r] = RW'(r2_p[r*3]) + RW'(r2_p[r*3+1]) + RW'(r2_p[r*3+2]) + HALF;
            if (r3_row[r] > OW'(VMAX)) begin
                n4_out[r]  = VMAX;
                n4_clip[r] = 1'b1;
            end else if (r3_row[r] < OW'(VMIN)) begin
                n4_out[r]  = VMIN;
                n4_clip[r] = 1'b1;
            end else begin
                n4_out[r]  = r3_row[r][VW-1:0];
                n4_clip[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_vec.valid && i_vec.ready;
            end
            for (int k = 1; k < 5; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r0_m    <= n0_m;
            r0_v[0] <= i_vec.in_x;
            r0_v[1] <= i_vec.in_y;
            r0_v[2] <= i_vec.in_z;
        end
        if (n_rdy[1]) begin
            r1_ll <= n1_ll;
            r1_lh <= n1_lh;
            r1_hl <= n1_hl;
            r1_hh <= n1_hh;
        end
        if (n_rdy[2]) begin
            r2_p <= n2_p;
        end
        if (n_rdy[3]) begin
            for (int r = 0; r < 3; r++) begin
                r3_row[r] <= n3_sum[r][RW-1:2*QF];
            end
        end
        if (n_rdy[4]) begin
            r_out <= n4_out;
            r_sat <= |n4_clip;
        end
    end

    assign o_res.valid     = r_vld[4];
    assign o_res.out_x     = r_out[0];
    assign o_res.out_y     = r_out[1];
    assign o_res.out_z     = r_out[2];
    assign o_res.saturated = r_sat;

endmodule

`default_nettype wire

// ===== hdl/euler_quaternion_vector_rotator.sv =====
// An accepted input passes the five pipeline registers to its result. Throughput:
// one vector per cycle while the output is taken and no write or rebuild holds the
// input, set by the five-stage rotation pipeline. An angle register write starts
// the quaternion derivation (30 CORDIC iterations, the triple products on the
// shared multiplier, then the matrix) with the input held off. Reset (synchronous,
// active low) gives zero angles, the identity rotation and an empty pipeline.
// ----------------------------------------------------------------------------
// euler_quaternion_vector_rotator
// Rotates vectors by a quaternion built from roll, pitch and yaw registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euler_quaternion_vector_rotator import eqr_pkg::*; #(
    parameter int VEC_WIDTH      = VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eqr_in_if.sink            i_vec,
    eqr_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic signed [ANG_W-1:0] r_roll, r_pitch, r_yaw;
    logic                    n_wr;
    logic                    n_start;
    logic                    n_busy;
    logic signed [2*QUAT_FRAC_BITS+3:0] n_mat [9];

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_ROLL:  prdata = APB_DW'(r_roll);
            REG_PITCH: prdata = APB_DW'(r_pitch);
            REG_YAW:   prdata = APB_DW'(r_yaw);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        unique case (paddr[3:2]) inside
            REG_ROLL, REG_PITCH, REG_YAW: n_start = n_wr;
            default:                      n_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else if (n_wr) begin
            unique case (paddr[3:2])
                REG_ROLL:  r_roll  <= pwdata[ANG_W-1:0];
                REG_PITCH: r_pitch <= pwdata[ANG_W-1:0];
                REG_YAW:   r_yaw   <= pwdata[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    eqr_quat_gen #(
        .QF (QUAT_FRAC_BITS)
    ) u_quat_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_roll  (r_roll),
        .i_pitch (r_pitch),
        .i_yaw   (r_yaw),
        .o_busy  (n_busy),
        .o_mat   (n_mat)
    );

    // no new transaction while the matrix is being rebuilt
    eqr_rot_pipe #(
        .VW (VEC_WIDTH),
        .QF (QUAT_FRAC_BITS)
    ) u_rot_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (n_busy || n_wr),
        .i_mat   (n_mat),
        .i_vec   (i_vec),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== hdl/eqr_checker.sv =====
// ----------------------------------------------------------------------------
// eqr_checker
// Port-level checks on the rotator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eqr_checker import eqr_pkg::*; #(
    parameter int VW = VEC_WIDTH_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [VW-1:0]     i_out_x,
    input logic [VW-1:0]     i_out_y,
    input logic [VW-1:0]     i_out_z,
    input logic              i_out_sat,
    input logic              i_psel,
    input logic              i_penable,
    input logic              i_pwrite,
    input logic [APB_AW-1:0] i_paddr
);

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_z) && $stable(i_out_sat))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // an angle write blocks input while the quaternion is rebuilt
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite
            && (i_paddr[3:2] == REG_ROLL || i_paddr[3:2] == REG_PITCH
                || i_paddr[3:2] == REG_YAW)
        |=> !i_in_ready)
        else $error("input accepted during quaternion derivation");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |-> i_out_x == VMAX || i_out_x == VMIN
            || i_out_y == VMAX || i_out_y == VMIN
            || i_out_z == VMAX || i_out_z == VMIN)
        else $error("saturation flag without a clipped component");

endmodule

bind euler_quaternion_vector_rotator eqr_checker #(
    .VW (VEC_WIDTH)
) u_eqr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_out_sat   (o_res.saturated),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr)
);

`default_nettype wire

// ===== test/euler_quaternion_vector_rotator_tb.sv =====
// ----------------------------------------------------------------------------
// euler_quaternion_vector_rotator_tb
// Drives vectors and angle register writes into the rotator. A bit-exact
// predictor derives the quaternion from the angles and rotates each vector.
// Every result transaction is checked in order against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_quaternion_vector_rotator_tb;
    import eqr_pkg::*;

    localparam int  VW        = VEC_WIDTH_DEF;
    localparam int  QF        = QUAT_FRAC_DEF;
    localparam int  CYC_LIMIT = 400000;
    localparam int  DRAIN_CYC = 12;
    localparam logic ACT_FWD  = 1'b0;
    localparam logic ACT_REV  = 1'b1;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int  ANG_MIN   = -65536;
    localparam int  ANG_MAX   = 65535;

    typedef struct {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 sat;
    } rot_vec_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    eqr_in_if  #(.VW(VW)) vec_if ();
    eqr_out_if #(.VW(VW)) res_if ();

    euler_quaternion_vector_rotator #(.VEC_WIDTH(VW), .QUAT_FRAC_BITS(QF)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vec(vec_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    longint ang_roll, ang_pitch, ang_yaw;
    longint q_s, q_x, q_y, q_z;
    rot_vec_t rotated_q[$];
    int  errors = 0;
    int  cycles = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  rx_hold = 0;

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint wrap_angle(longint a);
        longint t;
        t = (a + HALF_TURN) % FULL_TURN;
        if (t < 0) t += FULL_TURN;
        return t - HALF_TURN;
    endfunction

    task automatic half_trig(input longint a, output longint c, output longint s);
        longint x, y, z, step, dx, dy;
        x = CORDIC_X0;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            case (i)
                0: step = 754974720;
                1: step = 445687602;
                2: step = 235489088;
                3: step = 119537938;
                4: step = 60000934;
                5: step = 30029717;
                6: step = 15018523;
                7: step = 7509720;
                8: step = 3754917;
                9: step = 1877466;
                10: step = 938734;
                default: step = (DEG_PER_RAD_Q24 + (longint'(1) << (i - 1))) >>> i;
            endcase
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= step;
            end else begin
                x += dx; y -= dy; z += step;
            end
        end
        c = x;
        s = y;
    endtask

    function automatic longint trip(longint a, longint b, longint c);
        return rnd_shift(rnd_shift(a * b, CORDIC_FRAC) * c, CORDIC_FRAC);
    endfunction

    function automatic longint quat_comp(longint v);
        longint one;
        one = longint'(1) << QF;
        v = rnd_shift(v, CORDIC_FRAC - QF);
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v;
    endfunction

    task automatic build_quat();
        longint r, p, y, cr, sr, cp, sp, cy, sy;
        r = wrap_angle(ang_roll);
        p = wrap_angle(ang_pitch);
        y = wrap_angle(ang_yaw);
        if (p < -QUARTER_TURN) p = -HALF_TURN - p;
        else if (p > QUARTER_TURN) p = HALF_TURN - p;
        half_trig(r, cr, sr);
        half_trig(p, cp, sp);
        half_trig(y, cy, sy);
        q_s = quat_comp(trip(cr, cp, cy) + trip(sr, sp, sy));
        q_x = quat_comp(trip(sr, cp, cy) - trip(cr, sp, sy));
        q_y = quat_comp(trip(cr, sp, cy) + trip(sr, cp, sy));
        q_z = quat_comp(trip(cr, cp, sy) - trip(sr, sp, cy));
    endtask

    // one matrix row dotted with the vector, rounded once, then clipped
    function automatic longint row_dot(longint m0, longint m1, longint m2,
                                       longint v0, longint v1, longint v2, ref bit sat);
        logic signed [127:0] acc;
        longint r;
        acc = 128'(m0) * 128'(v0) + 128'(m1) * 128'(v1) + 128'(m2) * 128'(v2);
        acc = acc + (128'sd1 <<< (2 * QF - 1));
        acc = acc >>> (2 * QF);
        r = acc[63:0];
        if (r > 64'sd2147483647) begin r = 64'sd2147483647; sat = 1'b1; end
        if (r < -64'sd2147483648) begin r = -64'sd2147483648; sat = 1'b1; end
        return r;
    endfunction

    function automatic rot_vec_t rotate_vec(logic act, longint vx, longint vy, longint vz);
        longint s, ux, uy, uz, d;
        bit sat;
        rot_vec_t o;
        s = q_s; ux = q_x; uy = q_y; uz = q_z;
        sat = 1'b0;
        if (act == ACT_REV) begin ux = -ux; uy = -uy; uz = -uz; end
        d = s * s - (ux * ux + uy * uy + uz * uz);
        o.x = row_dot(d + 2 * ux * ux, 2 * (ux * uy - s * uz), 2 * (ux * uz + s * uy),
                      vx, vy, vz, sat);
        o.y = row_dot(2 * (ux * uy + s * uz), d + 2 * uy * uy, 2 * (uy * uz - s * ux),
                      vx, vy, vz, sat);
        o.z = row_dot(2 * (ux * uz - s * uy), 2 * (uy * uz + s * ux), d + 2 * uz * uz,
                      vx, vy, vz, sat);
        o.sat = sat;
        return o;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        rot_vec_t e;
        cycles <= cycles + 1;
        if (res_if.valid && res_if.ready) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b", $realtime,
                         res_if.out_x, res_if.out_y, res_if.out_z, res_if.saturated);
                errors++;
            end else begin
                e = rotated_q.pop_front();
                if (res_if.out_x !== e.x || res_if.out_y !== e.y || res_if.out_z !== e.z ||
                    res_if.saturated !== e.sat) begin
                    $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b", $realtime,
                             e.x, e.y, e.z, e.sat);
                    $display("%0t:          act x=%0d y=%0d z=%0d sat=%0b", $realtime,
                             res_if.out_x, res_if.out_y, res_if.out_z, res_if.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver back-pressure
    initial res_if.ready = 1'b0;
    always @(negedge i_clk) begin
        int gap;
        if (rx_hold > 0) begin
            res_if.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            res_if.ready <= 1'b0;
            rx_hold = gap - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    initial begin
        vec_if.valid = 1'b0;
        vec_if.action = ACT_FWD;
        vec_if.in_x = '0;
        vec_if.in_y = '0;
        vec_if.in_z = '0;
    end

    task automatic send_vec(logic act, logic signed [VW-1:0] x, logic signed [VW-1:0] y,
                            logic signed [VW-1:0] z);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            vec_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        vec_if.valid  <= 1'b1;
        vec_if.action <= act;
        vec_if.in_x   <= x;
        vec_if.in_y   <= y;
        vec_if.in_z   <= z;
        forever begin
            @(posedge i_clk);
            if (vec_if.ready) break;
        end
        rotated_q.push_back(rotate_vec(act, x, y, z));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        vec_if.valid <= 1'b0;
        while (rotated_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_angle(logic [1:0] idx, int val);
        wait_drain();
        repeat (DRAIN_CYC) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (idx)
            REG_ROLL:  begin ang_roll  = longint'($signed(val[ANG_W-1:0])); build_quat(); end
            REG_PITCH: begin ang_pitch = longint'($signed(val[ANG_W-1:0])); build_quat(); end
            REG_YAW:   begin ang_yaw   = longint'($signed(val[ANG_W-1:0])); build_quat(); end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_angles(int r, int p, int y);
        write_angle(REG_ROLL, r);
        write_angle(REG_PITCH, p);
        write_angle(REG_YAW, y);
    endtask

    function automatic logic signed [VW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $signed(VW'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000));
            1, 2: return $signed(VW'($urandom_range(0, 200000)) - VW'(100000));
            default: return $signed(VW'($urandom));
        endcase
    endfunction

    function automatic int rand_angle();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? ANG_MAX : ANG_MIN;
            1: return $urandom_range(0, 3) * QUARTER_TURN - HALF_TURN;
            default: return int'($urandom_range(0, 131071)) + ANG_MIN;
        endcase
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_vec(logic'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp());
    endtask

    // identity quaternion out of reset, both extremes of x and y, the maximum of z
    task automatic test_identity();
        send_vec(ACT_FWD, 32'sh7fffffff, 32'sh80000000, 32'sh0);
        send_vec(ACT_REV, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
        send_vec(ACT_FWD, 32'sh00010000, 32'sh0, 32'sh55555555);
        send_vec(ACT_REV, 32'shaaaaaaaa, 32'sh00000001, 32'sh7fffffff);
    endtask

    // 45 degrees of roll and yaw with full-scale vectors forces clipping
    task automatic test_saturation();
        set_angles(45 * 128, 0, 45 * 128);
        send_vec(ACT_FWD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_vec(ACT_REV, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_vec(ACT_FWD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    endtask

    // pitch fold either side, wrap of out-of-range codes, spare register
    task automatic test_angle_edges();
        set_angles(ANG_MAX, 100 * 128, ANG_MIN);
        send_vec(ACT_FWD, 32'sh00010000, 32'sh00020000, 32'sh00030000);
        send_vec(ACT_REV, 32'sh00010000, 32'sh00020000, 32'sh00030000);
        set_angles(-HALF_TURN, -100 * 128, HALF_TURN - 1);
        send_vec(ACT_FWD, 32'sh00010000, 32'shfffe0000, 32'sh00030000);
        set_angles(0, QUARTER_TURN, 0);
        send_vec(ACT_FWD, 32'sh00010000, 32'sh0, 32'sh0);
        write_angle(REG_SPARE, 12345);
        send_vec(ACT_REV, 32'sh0, 32'sh00010000, 32'sh0);
        set_angles(0, -QUARTER_TURN, 0);
        send_vec(ACT_FWD, 32'sh0, 32'sh0, 32'sh00010000);
    endtask

    // long receiver hold-off fills the pipe, then a full drain
    task automatic test_backpressure();
        set_angles(rand_angle(), rand_angle(), rand_angle());
        @(negedge i_clk);
        rx_hold = 200;
        send_random(40);
        wait_drain();
        send_random(20);
    endtask

    task automatic test_random();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int ph = 0; ph < 7; ph++) begin
            set_angles(rand_angle(), rand_angle(), rand_angle());
            if ($urandom_range(0, 3) == 0) write_angle(REG_SPARE, rand_angle());
            send_random(100);
        end
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_angles(rand_angle(), rand_angle(), rand_angle());
        send_random(100);
    endtask

    initial begin
        ang_roll = 0; ang_pitch = 0; ang_yaw = 0;
        q_s = longint'(1) << QF; q_x = 0; q_y = 0; q_z = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_identity();
        test_saturation();
        test_angle_edges();
        test_backpressure();
        test_random();
        wait_drain();
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== euler_quaternion_vector_rotator.f =====
hdl/eqr_pkg.sv
hdl/eqr_if.sv
hdl/eqr_quat_gen.sv
hdl/eqr_rot_pipe.sv
hdl/euler_quaternion_vector_rotator.sv
hdl/eqr_checker.sv
test/euler_quaternion_vector_rotator_tb.sv
